// ----- rtl/snfcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_pkg: shared types and constants
// Command, operation and result codes, and the bundle passed from the
// front end to the back end.
// ----------------------------------------------------------------------------
package snfcs_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_XFER  = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  localparam logic [2:0] OP_PROG   = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_SERASE = 3'd2;
  localparam logic [2:0] OP_CERASE = 3'd3;
  localparam logic [2:0] OP_JEDEC  = 3'd4;
  localparam logic [2:0] OP_MFID   = 3'd5;
  localparam logic [2:0] OP_PDOWN  = 3'd6;
  localparam logic [2:0] OP_WAKE   = 3'd7;

  localparam logic [2:0] K_SEND    = 3'd0;
  localparam logic [2:0] K_RELEASE = 3'd1;
  localparam logic [2:0] K_READ    = 3'd2;
  localparam logic [2:0] K_ID      = 3'd3;
  localparam logic [2:0] K_WANT    = 3'd4;
  localparam logic [2:0] K_DONE    = 3'd5;
  localparam logic [2:0] K_REJECT  = 3'd6;

  localparam logic [7:0] FL_WREN   = 8'h06;
  localparam logic [7:0] FL_RDSR   = 8'h05;
  localparam logic [7:0] FL_READ   = 8'h03;
  localparam logic [7:0] FL_PP     = 8'h02;
  localparam logic [7:0] FL_SE     = 8'h20;
  localparam logic [7:0] FL_CE     = 8'hc7;
  localparam logic [7:0] FL_PD     = 8'hb9;
  localparam logic [7:0] FL_WAKE   = 8'hab;
  localparam logic [7:0] FL_MFID   = 8'h90;
  localparam logic [7:0] FL_JEDEC  = 8'h9f;
  localparam logic [7:0] FL_BUSY   = 8'h01;
  localparam logic [7:0] FL_DUMMY  = 8'ha5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  op;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] value;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/snfcs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_if: valid/ready channel
// Carries one payload of type T with a source and a sink modport.
// ----------------------------------------------------------------------------
interface snfcs_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/snfcs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_front: request intake
// Accepts input transactions and queues them in a two-entry FIFO for the
// sequencer core.
// ----------------------------------------------------------------------------
module snfcs_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire snfcs_pkg::req_t in_req,
  output logic             q_valid,
  input  wire              q_ready,
  output snfcs_pkg::req_t  q_req
);
  import snfcs_pkg::*;

  req_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_req;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/snfcs_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snfcs_core: command sequencer
// Updates the flash frame state for one queued transaction per cycle while
// the small output queue has room for three, and hands up to three results to it.
// ----------------------------------------------------------------------------
module snfcs_core #(
  parameter int PAGE_BYTES = 256
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_valid,
  output logic             q_ready,
  input  wire snfcs_pkg::req_t q_req,
  output logic             out_valid,
  input  wire              out_ready,
  output snfcs_pkg::res_t  out_res
);
  import snfcs_pkg::*;

  localparam int PW = $clog2(PAGE_BYTES);
  localparam int CW = PW + 1;

  typedef enum logic [11:0] {
    PH_IDLE     = 12'b000000000001,
    PH_WREN     = 12'b000000000010,
    PH_OPCODE   = 12'b000000000100,
    PH_ADDR     = 12'b000000001000,
    PH_READ     = 12'b000000010000,
    PH_WANT     = 12'b000000100000,
    PH_PDATA    = 12'b000001000000,
    PH_POLLCMD  = 12'b000010000000,
    PH_POLLDATA = 12'b000100000000,
    PH_IDCMD    = 12'b001000000000,
    PH_IDDATA   = 12'b010000000000,
    PH_SINGLE   = 12'b100000000000
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [23:0]   addr_r, addr_nxt;
  logic [15:0]   left_r, left_nxt;
  logic [CW-1:0] chunk_r, chunk_nxt;
  logic [1:0]    bidx_r, bidx_nxt;
  logic [23:0]   id_r, id_nxt;

  // Output queue: 4 entries, each step pushes up to three results.
  res_t        oq_r [4];
  logic [1:0]  owp_r, orp_r;
  logic [2:0]  ocnt_r;
  res_t        r0, r1, r2;
  logic [1:0]  nres;
  logic        go;

  logic [15:0] left_m1;
  logic [CW-1:0] room;
  logic [23:0] id_sh;

  function automatic res_t mk(input logic [2:0] k, input logic [23:0] v);
    res_t r;
    r.kind  = k;
    r.value = v;
    r.last  = 1'b0;
    return r;
  endfunction

  // One free-slot reserve is enough: accept only with room for three.
  assign q_ready = (ocnt_r <= 3'd1);
  assign go      = q_valid && q_ready;
  assign left_m1 = left_r - 16'd1;
  assign id_sh   = {id_r[15:0], q_req.data};

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    chunk_nxt = chunk_r;
    bidx_nxt  = bidx_r;
    id_nxt    = id_r;
    r0 = mk(K_REJECT, 24'd0);
    r1 = mk(K_REJECT, 24'd0);
    r2 = mk(K_REJECT, 24'd0);
    nres = 2'd1;
    room = CW'(PAGE_BYTES) - {1'b0, q_req.address[PW-1:0]};
    if (q_req.cmd == CMD_START) begin
      if (phase_r == PH_IDLE) begin
        op_nxt   = q_req.op;
        addr_nxt = q_req.address;
        left_nxt = q_req.length;
        bidx_nxt = 2'd0;
        id_nxt   = 24'd0;
        unique case (q_req.op)
          OP_PROG, OP_READ: begin
            if (q_req.length == 16'd0) begin
              r0 = mk(K_DONE, 24'd0);
            end else if (q_req.op == OP_PROG) begin
              chunk_nxt = ({16'd0, q_req.length} < 32'(room)) ? CW'(q_req.length) : room;
              phase_nxt = PH_WREN;
              r0 = mk(K_SEND, {16'd0, FL_WREN});
            end else begin
              phase_nxt = PH_OPCODE;
              r0 = mk(K_SEND, {16'd0, FL_READ});
            end
          end
          OP_SERASE, OP_CERASE: begin
            phase_nxt = PH_WREN;
            r0 = mk(K_SEND, {16'd0, FL_WREN});
          end
          OP_JEDEC: begin
            phase_nxt = PH_IDCMD;
            r0 = mk(K_SEND, {16'd0, FL_JEDEC});
          end
          OP_MFID: begin
            phase_nxt = PH_IDCMD;
            r0 = mk(K_SEND, {16'd0, FL_MFID});
          end
          OP_PDOWN: begin
            phase_nxt = PH_SINGLE;
            r0 = mk(K_SEND, {16'd0, FL_PD});
          end
          default: begin
            phase_nxt = PH_SINGLE;
            r0 = mk(K_SEND, {16'd0, FL_WAKE});
          end
        endcase
      end
    end else if (q_req.cmd == CMD_XFER) begin
      unique case (phase_r)
        PH_WREN: begin
          phase_nxt = PH_OPCODE;
          r0 = mk(K_RELEASE, 24'd0);
          nres = 2'd2;
          if (op_r == OP_PROG) r1 = mk(K_SEND, {16'd0, FL_PP});
          else if (op_r == OP_SERASE) r1 = mk(K_SEND, {16'd0, FL_SE});
          else r1 = mk(K_SEND, {16'd0, FL_CE});
        end
        PH_OPCODE: begin
          if (op_r == OP_CERASE) begin
            phase_nxt = PH_POLLCMD;
            r0 = mk(K_RELEASE, 24'd0);
            r1 = mk(K_SEND, {16'd0, FL_RDSR});
            nres = 2'd2;
          end else begin
            bidx_nxt  = 2'd0;
            phase_nxt = PH_ADDR;
            r0 = mk(K_SEND, {16'd0, addr_r[23:16]});
          end
        end
        PH_ADDR: begin
          if (bidx_r < 2'd2) begin
            bidx_nxt = bidx_r + 2'd1;
            r0 = mk(K_SEND, {16'd0, (bidx_r == 2'd0) ? addr_r[15:8] : addr_r[7:0]});
          end else begin
            bidx_nxt = 2'd0;
            if (op_r == OP_SERASE) begin
              phase_nxt = PH_POLLCMD;
              r0 = mk(K_RELEASE, 24'd0);
              r1 = mk(K_SEND, {16'd0, FL_RDSR});
              nres = 2'd2;
            end else if (op_r == OP_READ) begin
              phase_nxt = PH_READ;
              r0 = mk(K_SEND, {16'd0, FL_DUMMY});
            end else begin
              phase_nxt = PH_WANT;
              r0 = mk(K_WANT, 24'd0);
            end
          end
        end
        PH_READ: begin
          r0 = mk(K_READ, {16'd0, q_req.data});
          left_nxt = left_m1;
          if (left_m1 != 16'd0) begin
            r1 = mk(K_SEND, {16'd0, FL_DUMMY});
            nres = 2'd2;
          end else begin
            r1 = mk(K_RELEASE, 24'd0);
            r2 = mk(K_DONE, 24'd0);
            nres = 2'd3;
            phase_nxt = PH_IDLE;
          end
        end
        PH_PDATA: begin
          chunk_nxt = chunk_r - CW'(1);
          left_nxt  = left_m1;
          addr_nxt  = addr_r + 24'd1;
          if (chunk_r != CW'(1)) begin
            phase_nxt = PH_WANT;
            r0 = mk(K_WANT, 24'd0);
          end else begin
            phase_nxt = PH_POLLCMD;
            r0 = mk(K_RELEASE, 24'd0);
            r1 = mk(K_SEND, {16'd0, FL_RDSR});
            nres = 2'd2;
          end
        end
        PH_POLLCMD: begin
          phase_nxt = PH_POLLDATA;
          r0 = mk(K_SEND, {16'd0, FL_DUMMY});
        end
        PH_POLLDATA: begin
          if ((q_req.data & FL_BUSY) != 8'd0) begin
            r0 = mk(K_SEND, {16'd0, FL_DUMMY});
          end else begin
            r0 = mk(K_RELEASE, 24'd0);
            nres = 2'd2;
            if (op_r == OP_PROG && left_r != 16'd0) begin
              room = CW'(PAGE_BYTES) - {1'b0, addr_r[PW-1:0]};
              chunk_nxt = ({16'd0, left_r} < 32'(room)) ? CW'(left_r) : room;
              phase_nxt = PH_WREN;
              r1 = mk(K_SEND, {16'd0, FL_WREN});
            end else begin
              phase_nxt = PH_IDLE;
              r1 = mk(K_DONE, 24'd0);
            end
          end
        end
        PH_IDCMD: begin
          bidx_nxt  = 2'd0;
          id_nxt    = 24'd0;
          phase_nxt = PH_IDDATA;
          r0 = mk(K_SEND, {16'd0, FL_DUMMY});
        end
        PH_IDDATA: begin
          id_nxt = id_sh;
          if (bidx_r < 2'd2) begin
            bidx_nxt = bidx_r + 2'd1;
            r0 = mk(K_SEND, {16'd0, FL_DUMMY});
          end else begin
            bidx_nxt = 2'd0;
            r0 = mk(K_RELEASE, 24'd0);
            r1 = mk(K_ID, id_sh);
            r2 = mk(K_DONE, 24'd0);
            nres = 2'd3;
            phase_nxt = PH_IDLE;
          end
        end
        PH_SINGLE: begin
          r0 = mk(K_RELEASE, 24'd0);
          r1 = mk(K_DONE, 24'd0);
          nres = 2'd2;
          phase_nxt = PH_IDLE;
        end
        default: begin
          r0 = mk(K_REJECT, 24'd0);
        end
      endcase
    end else if (q_req.cmd == CMD_DATA && phase_r == PH_WANT) begin
      phase_nxt = PH_PDATA;
      r0 = mk(K_SEND, {16'd0, q_req.data});
    end
    case (nres)
      2'd1:    r0.last = 1'b1;
      2'd2:    r1.last = 1'b1;
      default: r2.last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= 3'd0;
      addr_r  <= 24'd0;
      left_r  <= 16'd0;
      chunk_r <= '0;
      bidx_r  <= 2'd0;
      id_r    <= 24'd0;
    end else if (go) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      chunk_r <= chunk_nxt;
      bidx_r  <= bidx_nxt;
      id_r    <= id_nxt;
    end
  end

  logic pop;
  assign out_valid = (ocnt_r != 3'd0);
  assign out_res   = oq_r[orp_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 2'd0;
      orp_r  <= 2'd0;
      ocnt_r <= 3'd0;
    end else begin
      owp_r  <= owp_r + (go ? nres : 2'd0);
      orp_r  <= orp_r + {1'b0, pop};
      ocnt_r <= ocnt_r + (go ? {1'b0, nres} : 3'd0) - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      oq_r[owp_r] <= r0;
      if (nres >= 2'd2) oq_r[owp_r + 2'd1] <= r1;
      if (nres == 2'd3) oq_r[owp_r + 2'd2] <= r2;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/spi_nor_flash_command_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer: serial NOR flash command sequencer
// Turns host requests, finished SPI bytes and program data into the flash
// byte stream with select framing, read data, identifiers and status codes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per host request, finished SPI byte or program
//           data byte (cmd, op, address, length, data).
//   out_* : results (kind, value, last); one input yields one to three
//           results, the final one flagged by last.
//   A two-entry intake FIFO feeds the sequencer core, which takes one
//   transaction per cycle as long as its four-entry result queue holds at
//   most one result. Inputs are registered in the intake FIFO and results
//   in the result queue. Sustained rate is one input per cycle when each
//   input gives one result, set by the result queue draining one per cycle.
//   Synchronous reset empties both queues and returns the core to idle.
//   When the receiver stalls, results back up, the core stops once the result
//   queue holds two or more, and in_ready falls when the intake FIFO is full.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES = 256
) (
  input wire clk,
  input wire rst_n,
  snfcs_if.sink   in_ch,
  snfcs_if.source out_ch
);
  import snfcs_pkg::*;

  logic q_valid, q_ready;
  req_t q_req;

  snfcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_req   (in_ch.payload),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  snfcs_core #(.PAGE_BYTES(PAGE_BYTES)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_ch.payload)
  );
endmodule
`default_nettype wire
